// ----- rtl/core/kaed_pkg.sv -----
// Shared types and constants of the key and encoder debounce event block.
// Used by the front, back, top level and checker; depends on nothing else.
package kaed_pkg;

    localparam int RAW_W  = 16;
    localparam int TIME_W = 32;
    localparam int DB_W   = 16;

    // Configuration register indexes
    localparam logic CFG_KEY_DB = 1'b0;
    localparam logic CFG_ENC_DB = 1'b1;

    localparam logic [DB_W-1:0] DB_RESET = 16'd20;

    // Event kinds
    localparam logic [2:0] EV_KEY_DOWN = 3'd0;
    localparam logic [2:0] EV_KEY_UP   = 3'd1;
    localparam logic [2:0] EV_ROTATE   = 3'd2;
    localparam logic [2:0] EV_PRESS    = 3'd3;
    localparam logic [2:0] EV_RELEASE  = 3'd4;

    // Rotation codes
    localparam logic [1:0] DIR_STILL = 2'd0;
    localparam logic [1:0] DIR_CW    = 2'd1;
    localparam logic [1:0] DIR_CCW   = 2'd2;

    typedef struct packed {
        logic [RAW_W-1:0]  raw_keys;
        logic [TIME_W-1:0] now_ms;
        logic [1:0]        enc1_dir;
        logic              enc1_button;
        logic [1:0]        enc2_dir;
        logic              enc2_button;
    } t_scan;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [3:0] key_index;
        logic       encoder_id;
        logic [1:0] direction;
        logic       last;
    } t_event;

    // Classified scan as it waits in the queue
    typedef struct packed {
        logic [RAW_W-1:0]  keys;
        logic [TIME_W-1:0] now_ms;
        logic [1:0]        dir1;
        logic              rot1;
        logic              btn1;
        logic [1:0]        dir2;
        logic              rot2;
        logic              btn2;
    } t_job;

    typedef enum logic [1:0] {
        BS_IDLE = 2'b01,
        BS_RUN  = 2'b10
    } t_bstate;

endpackage

// ----- rtl/core/kaed_front.sv -----
// Front part: accepts scan items, classifies them and queues them (two deep).
// Depends on kaed_pkg.
module kaed_front #(
    parameter int KEY_COUNT = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  kaed_pkg::t_scan i_in_item,
    output logic           o_in_stall,
    output logic           o_job_vld,
    output kaed_pkg::t_job o_job,
    input  logic           i_job_pop
);
    import kaed_pkg::*;

    localparam logic [RAW_W-1:0] KEY_MASK = {RAW_W{1'b1}} >> (RAW_W - KEY_COUNT);

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_job       cls;
    logic       push, pop;

    // Classify: drop keys outside the matrix, flag real rotations
    always_comb begin
        cls.keys   = i_in_item.raw_keys & KEY_MASK;
        cls.now_ms = i_in_item.now_ms;
        cls.dir1   = i_in_item.enc1_dir;
        cls.rot1   = (i_in_item.enc1_dir == DIR_CW) || (i_in_item.enc1_dir == DIR_CCW);
        cls.btn1   = i_in_item.enc1_button;
        cls.dir2   = i_in_item.enc2_dir;
        cls.rot2   = (i_in_item.enc2_dir == DIR_CW) || (i_in_item.enc2_dir == DIR_CCW);
        cls.btn2   = i_in_item.enc2_button;
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_job_pop && (r_cnt != 2'd0);
    assign o_job_vld  = (r_cnt != 2'd0);
    assign o_job      = r_q[r_rp];

    // Store queue entries
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/core/kaed_back.sv -----
// Back part: walks one queued scan step by step, keeps the debounce state,
// and delivers events through a hold stage and an output register. Uses kaed_pkg.
module kaed_back #(
    parameter int KEY_COUNT = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_job_vld,
    input  kaed_pkg::t_job    i_job,
    output logic              o_job_pop,
    output logic              o_out_valid,
    output kaed_pkg::t_event  o_out_item,
    input  logic              i_out_stall
);
    import kaed_pkg::*;

    localparam int SW = $clog2(KEY_COUNT + 5);
    localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam logic [SW-1:0] ST_E0R  = SW'(KEY_COUNT);
    localparam logic [SW-1:0] ST_E0B  = SW'(KEY_COUNT + 1);
    localparam logic [SW-1:0] ST_E1R  = SW'(KEY_COUNT + 2);
    localparam logic [SW-1:0] ST_E1B  = SW'(KEY_COUNT + 3);
    localparam logic [SW-1:0] ST_DONE = SW'(KEY_COUNT + 4);

    t_bstate            r_state;
    logic [SW-1:0]      r_step;
    t_job               r_job;
    t_event             r_hold;
    logic               r_hold_vld;
    t_event             r_out;
    logic               r_out_vld;
    logic [DB_W-1:0]    r_key_db, r_enc_db;
    logic [KEY_COUNT-1:0] r_stable;
    logic [TIME_W-1:0]  r_key_time [KEY_COUNT];
    logic [1:0]         r_enc_stable;
    logic [TIME_W-1:0]  r_enc_time [2];

    logic [KW-1:0]      key_i;
    logic               enc_id;
    logic               btn;
    logic [TIME_W-1:0]  age;
    logic [TIME_W-1:0]  thr;
    logic               late;
    logic               ev_fire, key_upd, enc_upd;
    t_event             ev;
    logic               out_free, can_go, advance, push, finish;
    t_event             push_data;

    assign key_i  = r_step[KW-1:0];
    assign enc_id = (r_step == ST_E1R) || (r_step == ST_E1B);
    assign btn    = enc_id ? r_job.btn2 : r_job.btn1;

    // Pick the age and threshold of the current key or button
    always_comb begin
        if (r_step < ST_E0R) begin
            age = r_job.now_ms - r_key_time[key_i];
            thr = TIME_W'(r_key_db);
        end else begin
            age = r_job.now_ms - r_enc_time[enc_id];
            thr = TIME_W'(r_enc_db);
        end
    end
    assign late = age > thr;

    // Decide whether the current step gives an event
    always_comb begin
        ev_fire        = 1'b0;
        key_upd        = 1'b0;
        enc_upd        = 1'b0;
        ev.event_kind  = EV_KEY_DOWN;
        ev.key_index   = 4'd0;
        ev.encoder_id  = enc_id;
        ev.direction   = DIR_STILL;
        ev.last        = 1'b0;
        if (r_step < ST_E0R) begin
            ev.encoder_id = 1'b0;
            ev.key_index  = 4'(r_step);
            ev.event_kind = r_job.keys[key_i] ? EV_KEY_DOWN : EV_KEY_UP;
            key_upd       = (r_job.keys[key_i] != r_stable[key_i]) && late;
            ev_fire       = key_upd;
        end else if (r_step == ST_E0R) begin
            ev.event_kind = EV_ROTATE;
            ev.direction  = r_job.dir1;
            ev_fire       = r_job.rot1;
        end else if (r_step == ST_E1R) begin
            ev.event_kind = EV_ROTATE;
            ev.direction  = r_job.dir2;
            ev_fire       = r_job.rot2;
        end else if ((r_step == ST_E0B) || (r_step == ST_E1B)) begin
            ev.event_kind = btn ? EV_PRESS : EV_RELEASE;
            enc_upd       = (btn != r_enc_stable[enc_id]) && late;
            ev_fire       = enc_upd;
        end
    end

    // Handshake between sequencer, hold stage and output register
    always_comb begin
        out_free  = !r_out_vld || !i_out_stall;
        can_go    = !ev_fire || !r_hold_vld || out_free;
        advance   = 1'b0;
        push      = 1'b0;
        finish    = 1'b0;
        push_data = r_hold;
        o_job_pop = 1'b0;
        unique case (r_state)
            BS_IDLE: begin
                o_job_pop = i_job_vld;
            end
            BS_RUN: begin
                if (r_step != ST_DONE) begin
                    advance = can_go;
                    push    = ev_fire && r_hold_vld && can_go;
                end else if (r_hold_vld) begin
                    push           = out_free;
                    push_data.last = 1'b1;
                    finish         = out_free;
                end else begin
                    finish = 1'b1;
                end
            end
            default: begin
                o_job_pop = 1'b0;
            end
        endcase
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // Hold payload registers
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
        if (advance && ev_fire) begin
            r_hold <= ev;
        end
        if (push) begin
            r_out <= push_data;
        end
    end

    // Sequence, debounce state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BS_IDLE;
            r_step       <= '0;
            r_hold_vld   <= 1'b0;
            r_out_vld    <= 1'b0;
            r_key_db     <= DB_RESET;
            r_enc_db     <= DB_RESET;
            r_stable     <= '0;
            r_enc_stable <= 2'b00;
            for (int k = 0; k < KEY_COUNT; k++) begin
                r_key_time[k] <= '0;
            end
            r_enc_time[0] <= '0;
            r_enc_time[1] <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_KEY_DB) begin
                    r_key_db <= i_cfg_data;
                end else if (i_cfg_idx == CFG_ENC_DB) begin
                    r_enc_db <= i_cfg_data;
                end
            end
            if (push) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (o_job_pop) begin
                r_state <= BS_RUN;
                r_step  <= '0;
            end
            if (advance) begin
                r_step <= r_step + SW'(1);
                if (ev_fire) begin
                    r_hold_vld <= 1'b1;
                end
                if (key_upd) begin
                    r_stable[key_i]   <= r_job.keys[key_i];
                    r_key_time[key_i] <= r_job.now_ms;
                end
                if (enc_upd) begin
                    r_enc_stable[enc_id] <= btn;
                    r_enc_time[enc_id]   <= r_job.now_ms;
                end
            end
            if (finish) begin
                r_hold_vld <= 1'b0;
                r_state    <= BS_IDLE;
            end
        end
    end

endmodule

// ----- rtl/core/key_and_encoder_debounce_events.sv -----
// Top level of the key matrix and encoder debounce event generator.
// Joins kaed_front and kaed_back; types from kaed_pkg.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-------------------------
//  scan in  | i_in_valid   | o_in_stall   | i_in_item  (t_scan)
//  event out| o_out_valid  | i_out_stall  | o_out_item (t_event)
//  config   | i_cfg_we     | (none)       | i_cfg_idx, i_cfg_data
//
// In the back sequencer a scan passes one load, one step per key, four encoder
// steps and one flush; an event step or the flush waits while the hold stage
// is full and the output register holds a stalled event. A two-entry queue
// takes scans while the sequencer works. Synchronous active-low reset restores
// both debounce times to 20 ms and clears all stable levels and timestamps.
module key_and_encoder_debounce_events #(
    parameter int KEY_COUNT = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_in_valid,
    input  kaed_pkg::t_scan   i_in_item,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output kaed_pkg::t_event  o_out_item,
    input  logic              i_out_stall
);
    import kaed_pkg::*;

    logic job_vld;
    logic job_pop;
    t_job job;

    kaed_front #(
        .KEY_COUNT (KEY_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .o_job_vld  (job_vld),
        .o_job      (job),
        .i_job_pop  (job_pop)
    );

    kaed_back #(
        .KEY_COUNT (KEY_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_job_vld   (job_vld),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

// ----- rtl/core/kaed_checker.sv -----
// Port-level checker for the debounce event block, bound to the top level.
// Depends on kaed_pkg.
module kaed_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input kaed_pkg::t_event o_out_item,
    input logic             i_out_stall
);
    import kaed_pkg::*;

    // Hold a stalled event
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled event dropped or changed");

    // Keep kinds in range
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.event_kind == EV_KEY_DOWN) ||
                        (o_out_item.event_kind == EV_KEY_UP) ||
                        (o_out_item.event_kind == EV_ROTATE) ||
                        (o_out_item.event_kind == EV_PRESS) ||
                        (o_out_item.event_kind == EV_RELEASE))
        else $error("bad event kind");

    // Rotate events carry a real direction, others none
    a_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.event_kind == EV_ROTATE) ==
                         ((o_out_item.direction == DIR_CW) ||
                          (o_out_item.direction == DIR_CCW))))
        else $error("direction does not match event kind");

    // Key events name no encoder, encoder events name no key
    a_key_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_out_item.event_kind == EV_KEY_DOWN) ||
                        (o_out_item.event_kind == EV_KEY_UP))
        |-> (o_out_item.encoder_id == 1'b0))
        else $error("key event with encoder id");

    a_enc_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !((o_out_item.event_kind == EV_KEY_DOWN) ||
                         (o_out_item.event_kind == EV_KEY_UP))
        |-> (o_out_item.key_index == 4'd0))
        else $error("encoder event with key index");

endmodule

bind key_and_encoder_debounce_events kaed_checker u_kaed_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);

// ----- verif/key_and_encoder_debounce_events_test.sv -----
// Testbench for key_and_encoder_debounce_events: drives scans with directed and random
// content, predicts the debounce events internally and checks each output item in order.
// Depends on kaed_pkg and the key_and_encoder_debounce_events RTL only.
module key_and_encoder_debounce_events_test;
    import kaed_pkg::*;

    localparam int KEY_COUNT    = 16;
    localparam int SETTLE_TICKS = 100;
    localparam int RANDOM_PHASE = 80;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [DB_W-1:0]    i_cfg_data;
    logic               i_in_valid;
    t_scan              i_in_item;
    logic               o_in_stall;
    logic               o_out_valid;
    t_event             o_out_item;
    logic               i_out_stall;

    // Debounce state as the block should hold it
    logic [DB_W-1:0]    key_lockout;
    logic [DB_W-1:0]    enc_lockout;
    logic [RAW_W-1:0]   settled_keys;
    logic [TIME_W-1:0]  key_stamp [KEY_COUNT];
    logic               settled_btn [2];
    logic [TIME_W-1:0]  btn_stamp [2];

    t_event             expected_events [$];
    int                 error_count;
    int                 gap_pct;
    int                 stall_pct;

    // Random scan shaping
    logic [TIME_W-1:0]  scan_clock;
    logic [RAW_W-1:0]   held_keys;
    logic               held_btn1;
    logic               held_btn2;

    key_and_encoder_debounce_events #(
        .KEY_COUNT(KEY_COUNT)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item),
        .i_out_stall(i_out_stall)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    initial begin
        #40_000_000;
        $display("key_and_encoder_debounce_events_test: errors");
        $finish;
    end

    // Stall the event output at the current rate
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Compare each accepted event with the oldest prediction
    always @(posedge i_clk) begin
        t_event want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_events.size() == 0) begin
                note_error($sformatf("unexpected event kind=%0d key=%0d enc=%0d dir=%0d last=%0d",
                    o_out_item.event_kind, o_out_item.key_index, o_out_item.encoder_id,
                    o_out_item.direction, o_out_item.last));
            end else begin
                want = expected_events.pop_front();
                if (o_out_item.event_kind !== want.event_kind ||
                    o_out_item.key_index  !== want.key_index  ||
                    o_out_item.encoder_id !== want.encoder_id ||
                    o_out_item.direction  !== want.direction  ||
                    o_out_item.last       !== want.last) begin
                    note_error({
                        $sformatf("event mismatch: want kind=%0d key=%0d enc=%0d dir=%0d last=%0d",
                            want.event_kind, want.key_index, want.encoder_id,
                            want.direction, want.last),
                        $sformatf(", got kind=%0d key=%0d enc=%0d dir=%0d last=%0d",
                            o_out_item.event_kind, o_out_item.key_index,
                            o_out_item.encoder_id, o_out_item.direction, o_out_item.last)});
                end
            end
        end
    end

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    // Work out the events one scan causes and advance the debounce state
    function automatic void predict_scan_events(input t_scan s);
        t_event             found [$];
        t_event             ev;
        logic [TIME_W-1:0]  elapsed;
        logic [1:0]         dirs [2];
        logic               btns [2];
        dirs[0] = s.enc1_dir;
        dirs[1] = s.enc2_dir;
        btns[0] = s.enc1_button;
        btns[1] = s.enc2_button;
        for (int k = 0; k < KEY_COUNT; k++) begin
            elapsed = s.now_ms - key_stamp[k];
            if (s.raw_keys[k] != settled_keys[k] && elapsed > {16'd0, key_lockout}) begin
                key_stamp[k] = s.now_ms;
                settled_keys[k] = s.raw_keys[k];
                ev = '0;
                ev.event_kind = s.raw_keys[k] ? EV_KEY_DOWN : EV_KEY_UP;
                ev.key_index = k[3:0];
                found.push_back(ev);
            end
        end
        for (int e = 0; e < 2; e++) begin
            if (dirs[e] == DIR_CW || dirs[e] == DIR_CCW) begin
                ev = '0;
                ev.event_kind = EV_ROTATE;
                ev.encoder_id = e[0];
                ev.direction = dirs[e];
                found.push_back(ev);
            end
            elapsed = s.now_ms - btn_stamp[e];
            if (btns[e] != settled_btn[e] && elapsed > {16'd0, enc_lockout}) begin
                btn_stamp[e] = s.now_ms;
                settled_btn[e] = btns[e];
                ev = '0;
                ev.event_kind = btns[e] ? EV_PRESS : EV_RELEASE;
                ev.encoder_id = e[0];
                found.push_back(ev);
            end
        end
        if (found.size() > 0) begin
            found[found.size() - 1].last = 1'b1;
        end
        foreach (found[j]) begin
            expected_events.push_back(found[j]);
        end
    endfunction

    function automatic t_scan build_scan(input logic [RAW_W-1:0] raw,
                                         input logic [TIME_W-1:0] now,
                                         input logic [1:0] d1, input logic b1,
                                         input logic [1:0] d2, input logic b2);
        t_scan s;
        s.raw_keys = raw;
        s.now_ms = now;
        s.enc1_dir = d1;
        s.enc1_button = b1;
        s.enc2_dir = d2;
        s.enc2_button = b2;
        return s;
    endfunction

    // Offer one scan, idling at random first; valid stays high after acceptance
    task automatic send_scan(input t_scan s);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= s;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        predict_scan_events(s);
    endtask

    // Hold the input until every predicted event is out, then let the sequencer settle
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (expected_events.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // Write both lockout times; call only with the block idle
    task automatic set_lockouts(input logic [DB_W-1:0] key_ms, input logic [DB_W-1:0] enc_ms);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_KEY_DB;
        i_cfg_data <= key_ms;
        @(posedge i_clk);
        i_cfg_idx <= CFG_ENC_DB;
        i_cfg_data <= enc_ms;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        key_lockout = key_ms;
        enc_lockout = enc_ms;
    endtask

    // Reset lockouts: all keys and buttons at once, rejected up to and at the threshold
    task automatic test_reset_defaults();
        send_scan(build_scan(16'hFFFF, 32'd0, 2'd3, 1'b1, 2'd3, 1'b1));
        send_scan(build_scan(16'hFFFF, 32'd20, DIR_STILL, 1'b1, DIR_STILL, 1'b1));
        send_scan(build_scan(16'hFFFF, 32'd21, DIR_CW, 1'b1, DIR_CCW, 1'b1));
        send_scan(build_scan(16'h0000, 32'd100, DIR_STILL, 1'b0, DIR_STILL, 1'b0));
        wait_for_idle();
    endtask

    // Changes exactly at the lockout are rejected, one past it accepted
    task automatic test_threshold_edges();
        set_lockouts(16'd10, 16'd30);
        send_scan(build_scan(16'h0001, 32'd110, DIR_STILL, 1'b1, DIR_STILL, 1'b0));
        send_scan(build_scan(16'h0001, 32'd111, DIR_STILL, 1'b1, DIR_STILL, 1'b0));
        send_scan(build_scan(16'h0001, 32'd130, DIR_STILL, 1'b1, DIR_STILL, 1'b0));
        send_scan(build_scan(16'h0001, 32'd131, DIR_STILL, 1'b1, DIR_STILL, 1'b0));
    endtask

    // Rotation on both encoders, the meaningless direction code, and button edges
    task automatic test_encoders();
        send_scan(build_scan(16'h0001, 32'd300, 2'd3, 1'b1, 2'd3, 1'b0));
        send_scan(build_scan(16'h0001, 32'd301, DIR_CW, 1'b1, DIR_CCW, 1'b0));
        send_scan(build_scan(16'h0001, 32'd302, DIR_CCW, 1'b1, DIR_CW, 1'b1));
        send_scan(build_scan(16'h0001, 32'd303, DIR_STILL, 1'b0, DIR_STILL, 1'b1));
    endtask

    // Elapsed time across the 32-bit wrap, and a zero lockout
    task automatic test_time_wrap();
        send_scan(build_scan(16'h0000, 32'hFFFF_FFF0, DIR_STILL, 1'b0, DIR_STILL, 1'b1));
        send_scan(build_scan(16'h0001, 32'h0000_0005, DIR_STILL, 1'b0, DIR_STILL, 1'b1));
        send_scan(build_scan(16'h0000, 32'h0000_000F, DIR_STILL, 1'b0, DIR_STILL, 1'b1));
        send_scan(build_scan(16'h0000, 32'hFFFF_FFFF, DIR_STILL, 1'b0, DIR_STILL, 1'b1));
        wait_for_idle();
        set_lockouts(16'd0, 16'd0);
        send_scan(build_scan(16'h0001, 32'hFFFF_FFFF, DIR_STILL, 1'b0, DIR_STILL, 1'b1));
        send_scan(build_scan(16'h0001, 32'h0000_0000, DIR_STILL, 1'b0, DIR_STILL, 1'b1));
        wait_for_idle();
        scan_clock = 32'd0;
        held_keys = 16'h0001;
        held_btn1 = 1'b0;
        held_btn2 = 1'b1;
    endtask

    // Mostly a few keys bouncing against the lockout, with some wholly random scans
    function automatic t_scan random_scan();
        logic [TIME_W-1:0] step;
        case ($urandom_range(9))
            0: step = 0;
            1: step = {16'd0, key_lockout};
            2: step = {16'd0, key_lockout} + 1;
            3: step = {16'd0, enc_lockout};
            4: step = {16'd0, enc_lockout} + 1;
            5: step = $urandom();
            default: step = $urandom_range(2 * key_lockout + 3);
        endcase
        scan_clock = scan_clock + step;
        if ($urandom_range(9) == 0) begin
            held_keys = 16'($urandom());
        end else begin
            held_keys = held_keys ^ (16'd1 << $urandom_range(15));
            if ($urandom_range(1)) begin
                held_keys = held_keys ^ (16'd1 << $urandom_range(15));
            end
        end
        if ($urandom_range(9) < 3) begin
            held_btn1 = ~held_btn1;
        end
        if ($urandom_range(9) < 3) begin
            held_btn2 = ~held_btn2;
        end
        return build_scan(held_keys, scan_clock, 2'($urandom_range(3)), held_btn1,
                          2'($urandom_range(3)), held_btn2);
    endfunction

    task automatic run_phase(input logic [DB_W-1:0] key_ms, input logic [DB_W-1:0] enc_ms,
                             input int sender_gap, input int receiver_stall);
        wait_for_idle();
        set_lockouts(key_ms, enc_ms);
        gap_pct = sender_gap;
        stall_pct = receiver_stall;
        repeat (RANDOM_PHASE) begin
            send_scan(random_scan());
        end
    endtask

    // Random traffic across lockout settings and idling patterns
    task automatic test_random_traffic();
        run_phase(16'd0, 16'd0, 0, 0);
        run_phase(16'hFFFF, 16'hFFFF, 45, 0);
        run_phase(16'($urandom_range(40, 1)), 16'($urandom_range(40, 1)), 0, 45);
        run_phase(16'd3, 16'd500, 14, 14);
        run_phase(16'($urandom_range(65535)), 16'($urandom_range(65535)), 45, 0);
        run_phase(16'd20, 16'd20, 0, 45);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_KEY_DB;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_in_item <= '0;
        error_count = 0;
        gap_pct = 0;
        stall_pct = 0;
        key_lockout = DB_RESET;
        enc_lockout = DB_RESET;
        settled_keys = '0;
        for (int k = 0; k < KEY_COUNT; k++) begin
            key_stamp[k] = '0;
        end
        for (int e = 0; e < 2; e++) begin
            settled_btn[e] = 1'b0;
            btn_stamp[e] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_threshold_edges();
        gap_pct = 45;
        stall_pct = 45;
        test_encoders();
        gap_pct = 0;
        stall_pct = 0;
        test_time_wrap();
        test_random_traffic();

        wait_for_idle();
        if (error_count == 0 && expected_events.size() == 0) begin
            $display("key_and_encoder_debounce_events_test: clean");
        end else begin
            $display("key_and_encoder_debounce_events_test: errors");
        end
        $finish;
    end

endmodule
